[hw/rtl/info_frame_stuffing_encoder_defines.svh]
// ----------------------------------------------------------------------------
// info frame stuffing encoder assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef INFO_FRAME_STUFFING_ENCODER_DEFINES_SVH
`define INFO_FRAME_STUFFING_ENCODER_DEFINES_SVH

// expression holds at every edge out of reset
`define IFSE_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the same edge
`define IFSE_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define IFSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ifse_pkg.sv]
// ----------------------------------------------------------------------------
// ifse_pkg
// types and constants shared by the information frame stuffing encoder
// ----------------------------------------------------------------------------
package ifse_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FLAG_VALUE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_VALUE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLAG_SUBSTITUTE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_SUBSTITUTE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_VALUE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_SEQ_ZERO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_SEQ_ONE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_BIT      = 3'd7;

    // register reset values
    localparam logic [BYTE_W-1:0] RST_FLAG_VALUE        = 8'd126;
    localparam logic [BYTE_W-1:0] RST_ESCAPE_VALUE      = 8'd125;
    localparam logic [BYTE_W-1:0] RST_FLAG_SUBSTITUTE   = 8'd94;
    localparam logic [BYTE_W-1:0] RST_ESCAPE_SUBSTITUTE = 8'd93;
    localparam logic [BYTE_W-1:0] RST_ADDRESS_VALUE     = 8'd3;
    localparam logic [BYTE_W-1:0] RST_CONTROL_SEQ_ZERO  = 8'd0;
    localparam logic [BYTE_W-1:0] RST_CONTROL_SEQ_ONE   = 8'd64;
    localparam logic              RST_SEQUENCE_BIT      = 1'b0;

    // most line bytes one payload byte may cause; later ones are dropped
    localparam int MAX_BEATS = 11;
    localparam int CNT_W     = $clog2(MAX_BEATS);

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic              run_end;
        logic              frame_end;
    } out_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_value;
        logic [BYTE_W-1:0] escape_value;
        logic [BYTE_W-1:0] flag_substitute;
        logic [BYTE_W-1:0] escape_substitute;
        logic [BYTE_W-1:0] address_value;
        logic [BYTE_W-1:0] control_seq_zero;
        logic [BYTE_W-1:0] control_seq_one;
        logic              sequence_bit;
    } cfg_t;

    // one classified payload byte handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] check;
        logic              hdr;
        logic              last;
    } qent_t;

endpackage

[hw/rtl/info_frame_stuffing_encoder.sv]
// ----------------------------------------------------------------------------
// info_frame_stuffing_encoder
// stuffed information frame builder with xor block checks
// ----------------------------------------------------------------------------
// Each payload beat yields a run of line beats, one line byte per clock while
// line_stall is low: a plain payload byte gives one line byte, a stuffed one
// an escape pair, and the first and last byte of a frame add the header
// (flag, address, control, BCC1) and the trailer (BCC2, closing flag), up to
// MAX_BEATS line bytes. Payload beats are taken every clock while the queue
// (two entries by default) has room, and a line stall fills it before
// payload_stall rises. Configuration is written through cfg_valid/cfg_ready,
// always ready; the user must only write while the block is idle (unchecked).
`include "info_frame_stuffing_encoder_defines.svh"

module info_frame_stuffing_encoder #(
    parameter int QUEUE_DEPTH = ifse_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                payload_valid,
    output logic                                payload_stall,
    input  ifse_pkg::in_beat_t                  payload,
    output logic                                line_valid,
    input  logic                                line_stall,
    output ifse_pkg::out_beat_t                 line,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ifse_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ifse_pkg::BYTE_W-1:0]         cfg_data
);
    import ifse_pkg::*;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  push;
    qent_t push_entry;
    logic  full;
    logic  pop;
    logic  head_valid;
    qent_t head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FLAG_VALUE:        cfg_next.flag_value        = cfg_data;
                REG_ESCAPE_VALUE:      cfg_next.escape_value      = cfg_data;
                REG_FLAG_SUBSTITUTE:   cfg_next.flag_substitute   = cfg_data;
                REG_ESCAPE_SUBSTITUTE: cfg_next.escape_substitute = cfg_data;
                REG_ADDRESS_VALUE:     cfg_next.address_value     = cfg_data;
                REG_CONTROL_SEQ_ZERO:  cfg_next.control_seq_zero  = cfg_data;
                REG_CONTROL_SEQ_ONE:   cfg_next.control_seq_one   = cfg_data;
                REG_SEQUENCE_BIT:      cfg_next.sequence_bit      = cfg_data[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_value        <= RST_FLAG_VALUE;
            cfg_reg.escape_value      <= RST_ESCAPE_VALUE;
            cfg_reg.flag_substitute   <= RST_FLAG_SUBSTITUTE;
            cfg_reg.escape_substitute <= RST_ESCAPE_SUBSTITUTE;
            cfg_reg.address_value     <= RST_ADDRESS_VALUE;
            cfg_reg.control_seq_zero  <= RST_CONTROL_SEQ_ZERO;
            cfg_reg.control_seq_one   <= RST_CONTROL_SEQ_ONE;
            cfg_reg.sequence_bit      <= RST_SEQUENCE_BIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ifse_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .payload_valid (payload_valid),
        .payload_stall (payload_stall),
        .payload       (payload),
        .full          (full),
        .push          (push),
        .push_entry    (push_entry)
    );

    ifse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    ifse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .line_valid (line_valid),
        .line_stall (line_stall),
        .line       (line)
    );

    `IFSE_ASSERT_IMPLY(a_pop_has_head, pop, head_valid, "pop from empty queue")
    `IFSE_ASSERT_NEXT(a_accept_line, payload_valid && !payload_stall, head_valid,
        "accepted beat not queued")
    `IFSE_ASSERT_NEXT(a_line_hold, line_valid && line_stall, line_valid,
        "stalled line beat withdrawn")

endmodule

[hw/rtl/ifse_front.sv]
// ----------------------------------------------------------------------------
// ifse_front
// accepts payload beats, tracks frame position and the running xor check
// ----------------------------------------------------------------------------
module ifse_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             payload_valid,
    output logic             payload_stall,
    input  ifse_pkg::in_beat_t payload,
    input  logic             full,
    output logic             push,
    output ifse_pkg::qent_t  push_entry
);
    import ifse_pkg::*;

    logic              in_frame_reg;
    logic              in_frame_next;
    logic [BYTE_W-1:0] check_reg;
    logic [BYTE_W-1:0] check_next;
    logic [BYTE_W-1:0] check_sum;

    assign payload_stall = full;
    assign push          = payload_valid && !full;

    always_comb
    begin
        // a new frame restarts the check from zero
        check_sum = (in_frame_reg ? check_reg : '0) ^ payload.payload_byte;

        push_entry.data  = payload.payload_byte;
        push_entry.check = check_sum;
        push_entry.hdr   = !in_frame_reg;
        push_entry.last  = payload.last_byte;

        in_frame_next = in_frame_reg;
        check_next    = check_reg;
        if (push)
        begin
            in_frame_next = !payload.last_byte;
            check_next    = payload.last_byte ? '0 : check_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            check_reg    <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            check_reg    <= check_next;
        end
    end

endmodule

[hw/rtl/ifse_queue.sv]
// ----------------------------------------------------------------------------
// ifse_queue
// short first-in first-out queue of classified beats between front and back
// ----------------------------------------------------------------------------
`include "info_frame_stuffing_encoder_defines.svh"

module ifse_queue #(
    parameter int DEPTH = ifse_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ifse_pkg::qent_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output ifse_pkg::qent_t head
);
    import ifse_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qent_t         entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `IFSE_ASSERT_IMPLY(a_no_push_full, full, !push, "push into full queue")
    `IFSE_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH), "queue count past depth")
    `IFSE_ASSERT_NEXT(a_count_step, push && !do_pop, count_reg == $past(count_reg) + 1'b1,
        "queue count missed a push")

endmodule

[hw/rtl/ifse_back.sv]
// ----------------------------------------------------------------------------
// ifse_back
// walks the frame segments of each queued beat and sends stuffed line bytes
// ----------------------------------------------------------------------------
`include "info_frame_stuffing_encoder_defines.svh"

module ifse_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ifse_pkg::cfg_t     cfg,
    input  logic               head_valid,
    input  ifse_pkg::qent_t    head,
    output logic               pop,
    output logic               line_valid,
    input  logic               line_stall,
    output ifse_pkg::out_beat_t line
);
    import ifse_pkg::*;

    localparam logic [2:0] SEG_OPEN  = 3'd0;
    localparam logic [2:0] SEG_ADDR  = 3'd1;
    localparam logic [2:0] SEG_CTRL  = 3'd2;
    localparam logic [2:0] SEG_BCC1  = 3'd3;
    localparam logic [2:0] SEG_DATA  = 3'd4;
    localparam logic [2:0] SEG_BCC2  = 3'd5;
    localparam logic [2:0] SEG_CLOSE = 3'd6;

    logic [2:0]       seg_reg;
    logic [2:0]       seg_next;
    logic             first_reg;
    logic             first_next;
    logic             half_reg;
    logic             half_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_beat_t        out_reg;
    out_beat_t        out_next;

    logic [2:0]        cur_seg;
    logic [2:0]        follow_seg;
    logic [BYTE_W-1:0] ctrl;
    logic [BYTE_W-1:0] src;
    logic [BYTE_W-1:0] byte_out;
    logic              stuffable;
    logic              is_flag;
    logic              is_esc;
    logic              pair;
    logic              seg_done;
    logic              seg_final;
    logic              entry_end;
    logic              out_adv;
    logic              emit;

    assign out_adv    = !out_valid_reg || !line_stall;
    assign emit       = head_valid && out_adv;
    assign line_valid = out_valid_reg;
    assign line       = out_reg;

    always_comb
    begin
        cur_seg = first_reg ? (head.hdr ? SEG_OPEN : SEG_DATA) : seg_reg;
        ctrl    = cfg.sequence_bit ? cfg.control_seq_one : cfg.control_seq_zero;

        src        = cfg.flag_value;
        stuffable  = 1'b1;
        follow_seg = SEG_CLOSE;
        seg_final  = 1'b0;
        case (cur_seg)
            SEG_OPEN:
            begin
                stuffable  = 1'b0;
                follow_seg = SEG_ADDR;
            end
            SEG_ADDR:
            begin
                src        = cfg.address_value;
                follow_seg = SEG_CTRL;
            end
            SEG_CTRL:
            begin
                src        = ctrl;
                follow_seg = SEG_BCC1;
            end
            SEG_BCC1:
            begin
                src        = cfg.address_value ^ ctrl;
                follow_seg = SEG_DATA;
            end
            SEG_DATA:
            begin
                src        = head.data;
                follow_seg = SEG_BCC2;
                seg_final  = !head.last;
            end
            SEG_BCC2:
            begin
                src        = head.check;
                follow_seg = SEG_CLOSE;
            end
            SEG_CLOSE:
            begin
                stuffable = 1'b0;
                seg_final = 1'b1;
            end
            default:
            begin
                stuffable = 1'b0;
                seg_final = 1'b1;
            end
        endcase

        // a byte matching both flag and escape is stuffed with the flag substitute
        is_flag = (src == cfg.flag_value);
        is_esc  = (src == cfg.escape_value);
        pair    = stuffable && (is_flag || is_esc);

        if (half_reg)
        begin
            byte_out = is_flag ? cfg.flag_substitute : cfg.escape_substitute;
        end
        else
        begin
            byte_out = pair ? cfg.escape_value : src;
        end

        seg_done  = !pair || half_reg;
        // the beat budget cuts off an overlong run, which can only drop the closing flag
        entry_end = (seg_done && seg_final) || (cnt_reg == CNT_W'(MAX_BEATS - 1));
        pop       = emit && entry_end;

        seg_next   = seg_reg;
        first_next = first_reg;
        half_next  = half_reg;
        cnt_next   = cnt_reg;
        if (emit)
        begin
            if (entry_end)
            begin
                first_next = 1'b1;
                half_next  = 1'b0;
                cnt_next   = '0;
            end
            else
            begin
                first_next = 1'b0;
                cnt_next   = cnt_reg + 1'b1;
                half_next  = !seg_done;
                seg_next   = seg_done ? follow_seg : cur_seg;
            end
        end

        out_next           = out_reg;
        out_next.line_byte = byte_out;
        out_next.run_end   = entry_end;
        out_next.frame_end = (cur_seg == SEG_CLOSE);
        if (!emit)
        begin
            out_next = out_reg;
        end
        out_valid_next = emit ? 1'b1 : (out_valid_reg && line_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg       <= SEG_OPEN;
            first_reg     <= 1'b1;
            half_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seg_reg       <= seg_next;
            first_reg     <= first_next;
            half_reg      <= half_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    `IFSE_ASSERT_ALWAYS(a_cnt_bound, cnt_reg < CNT_W'(MAX_BEATS), "beat count past limit")
    `IFSE_ASSERT_IMPLY(a_half_mid, half_reg, !first_reg, "stuffed pair split across runs")
    `IFSE_ASSERT_IMPLY(a_frame_run, out_valid_reg && out_reg.frame_end, out_reg.run_end,
        "closing flag not last of its run")
    `IFSE_ASSERT_NEXT(a_pop_restart, pop, first_reg && !half_reg && cnt_reg == '0,
        "sequencer not rewound after run")

endmodule
